// ----- rtl/ppm_fd_pkg.sv -----
// ppm_fd_pkg: shared types, codes and constants of the ppm frame decoder
// no dependencies; used by every module of the block by scoped names

package ppm_fd_pkg;

  // operation codes as they arrive in the input beat
  localparam logic [2:0] OP_EDGE      = 3'd0;
  localparam logic [2:0] OP_READ      = 3'd1;
  localparam logic [2:0] OP_OVR_WRITE = 3'd2;
  localparam logic [2:0] OP_OVR_CLEAR = 3'd3;
  localparam logic [2:0] OP_POLL      = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIN_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_MAX_WIDTH      = 2'd2;

  // configuration reset values
  localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd3000;
  localparam logic [15:0] MIN_WIDTH_RST      = 16'd900;
  localparam logic [15:0] MAX_WIDTH_RST      = 16'd2100;

  // failsafe values returned without sync or for a channel out of range
  localparam logic [3:0]  FAILSAFE_LOW_CH = 4'd2;
  localparam logic [15:0] FAILSAFE_LOW    = 16'd900;
  localparam logic [15:0] FAILSAFE_MID    = 16'd1500;

  // slots above the channel count while acquiring sync
  localparam int unsigned ACQUIRE_EXTRA = 3;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // command kinds after classification in the front
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_EDGE,
    CMD_READ,
    CMD_OVR_WRITE,
    CMD_OVR_CLEAR,
    CMD_POLL
  } cmd_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        edge_time;
    logic [3:0]         channel;
    logic signed [15:0] override_value;
  } in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        override_taken;
    logic        has_sync;
    logic [3:0]  frame_channels;
    logic        frame_ready;
  } out_t;

  typedef struct packed {
    cmd_e               kind;
    logic [15:0]        edge_time;
    logic [3:0]         channel;
    logic signed [15:0] override_value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] sync_threshold;
    logic [15:0] min_width;
    logic [15:0] max_width;
  } cfg_t;

endpackage

// ----- rtl/ppm_fd_front.sv -----
// ppm_fd_front: input stage, takes input beats and classifies the operation
// depends on ppm_fd_pkg

module ppm_fd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppm_fd_pkg::in_t   in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output ppm_fd_pkg::cmd_t  cmd_o
);

  logic             valid_d, valid_q;
  ppm_fd_pkg::cmd_t cmd_d, cmd_q;
  logic             take;

  // stage is free when empty or when its beat moves on this cycle
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // operation decode
  always_comb begin
    cmd_d.edge_time      = in_data_i.edge_time;
    cmd_d.channel        = in_data_i.channel;
    cmd_d.override_value = in_data_i.override_value;
    unique case (in_data_i.operation)
      ppm_fd_pkg::OP_EDGE:      cmd_d.kind = ppm_fd_pkg::CMD_EDGE;
      ppm_fd_pkg::OP_READ:      cmd_d.kind = ppm_fd_pkg::CMD_READ;
      ppm_fd_pkg::OP_OVR_WRITE: cmd_d.kind = ppm_fd_pkg::CMD_OVR_WRITE;
      ppm_fd_pkg::OP_OVR_CLEAR: cmd_d.kind = ppm_fd_pkg::CMD_OVR_CLEAR;
      ppm_fd_pkg::OP_POLL:      cmd_d.kind = ppm_fd_pkg::CMD_POLL;
      default:                  cmd_d.kind = ppm_fd_pkg::CMD_NOP;
    endcase
  end

  // stage valid
  always_comb begin
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ----- rtl/ppm_fd_queue.sv -----
// ppm_fd_queue: short command queue between the front and the back unit
// depends on ppm_fd_pkg

module ppm_fd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ppm_fd_pkg::cmd_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ppm_fd_pkg::cmd_t  pop_data_o
);

  localparam int unsigned PtrW = (ppm_fd_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(ppm_fd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(ppm_fd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full     = CntW'(ppm_fd_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(ppm_fd_pkg::QUEUE_DEPTH - 1);

  ppm_fd_pkg::cmd_t    mem_q [ppm_fd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]     cnt_d, cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/ppm_fd_back.sv -----
// ppm_fd_back: execution unit, holds the decoder state and the result register
// depends on ppm_fd_pkg

module ppm_fd_back #(
  parameter int unsigned CHANNEL_COUNT = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppm_fd_pkg::cfg_t  cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  ppm_fd_pkg::cmd_t  cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ppm_fd_pkg::out_t  out_data_o
);

  localparam int unsigned SlotW = $clog2(CHANNEL_COUNT + ppm_fd_pkg::ACQUIRE_EXTRA + 1);
  localparam int unsigned IdxW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [SlotW-1:0] CcSlot   = SlotW'(CHANNEL_COUNT);
  localparam logic [SlotW-1:0] SlotRst  = SlotW'(CHANNEL_COUNT + ppm_fd_pkg::ACQUIRE_EXTRA);
  localparam logic [3:0]       CcCh     = 4'(CHANNEL_COUNT);

  // decoder state
  logic [15:0]      prev_d, prev_q;
  logic [SlotW-1:0] slot_d, slot_q;
  logic [3:0]       latched_d, latched_q;
  logic             flag_d, flag_q;
  logic [15:0]      chan_q [CHANNEL_COUNT];
  logic [14:0]      ovr_q  [CHANNEL_COUNT];

  // store write controls
  logic             chan_we;
  logic [IdxW-1:0]  chan_widx;
  logic [15:0]      chan_wdata;
  logic             ovr_we, ovr_clr;
  logic [IdxW-1:0]  ovr_widx;
  logic [14:0]      ovr_wdata;

  logic             out_valid_q;
  ppm_fd_pkg::out_t res_d, out_q;

  logic             pop;
  logic [15:0]      width;
  logic [15:0]      clamped;
  logic             synced, synced_next, ch_ok;
  logic [IdxW-1:0]  ch_idx;
  logic [14:0]      ovr_rd;
  logic [15:0]      chan_rd;

  // back unit moves when the result register is free or being drained
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // pulse width and clamp
  assign width = cmd_i.edge_time - prev_q;
  always_comb begin
    if (width < cfg_i.min_width) begin
      clamped = cfg_i.min_width;
    end else if (width > cfg_i.max_width) begin
      clamped = cfg_i.max_width;
    end else begin
      clamped = width;
    end
  end

  // channel lookups
  assign synced  = (slot_q <= CcSlot);
  assign ch_ok   = (cmd_i.channel < CcCh);
  assign ch_idx  = cmd_i.channel[IdxW-1:0];
  assign ovr_rd  = ovr_q[ch_idx];
  assign chan_rd = chan_q[ch_idx];

  // command execution
  always_comb begin
    prev_d     = prev_q;
    slot_d     = slot_q;
    latched_d  = latched_q;
    flag_d     = flag_q;
    chan_we    = 1'b0;
    chan_widx  = slot_q[IdxW-1:0];
    chan_wdata = clamped;
    ovr_we     = 1'b0;
    ovr_clr    = 1'b0;
    ovr_widx   = ch_idx;
    ovr_wdata  = cmd_i.override_value[14:0];
    res_d      = '0;
    unique case (cmd_i.kind)
      ppm_fd_pkg::CMD_EDGE: begin
        prev_d = cmd_i.edge_time;
        if (width < cfg_i.sync_threshold) begin
          if (slot_q < CcSlot) begin
            chan_we = 1'b1;
            slot_d  = slot_q + 1'b1;
          end
        end else if (synced) begin
          latched_d = 4'(slot_q);
          flag_d    = 1'b1;
          slot_d    = '0;
        end else begin
          slot_d = slot_q - 1'b1;
        end
      end
      ppm_fd_pkg::CMD_READ: begin
        if (synced && ch_ok) begin
          res_d.read_value = (ovr_rd != '0) ? {1'b0, ovr_rd} : chan_rd;
        end else if (cmd_i.channel == ppm_fd_pkg::FAILSAFE_LOW_CH) begin
          res_d.read_value = ppm_fd_pkg::FAILSAFE_LOW;
        end else begin
          res_d.read_value = ppm_fd_pkg::FAILSAFE_MID;
        end
      end
      ppm_fd_pkg::CMD_OVR_WRITE: begin
        if (ch_ok && !cmd_i.override_value[15]) begin
          ovr_we               = 1'b1;
          res_d.override_taken = (cmd_i.override_value != '0);
        end
      end
      ppm_fd_pkg::CMD_OVR_CLEAR: begin
        ovr_clr = 1'b1;
      end
      ppm_fd_pkg::CMD_POLL: begin
        if (synced) begin
          res_d.frame_ready = flag_q;
          flag_d            = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // status after the command
    synced_next          = (slot_d <= CcSlot);
    res_d.has_sync       = synced_next;
    res_d.frame_channels = synced_next ? latched_d : 4'd0;
  end

  // scalar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      slot_q    <= SlotRst;
      latched_q <= '0;
      flag_q    <= 1'b0;
    end else if (pop) begin
      prev_q    <= prev_d;
      slot_q    <= slot_d;
      latched_q <= latched_d;
      flag_q    <= flag_d;
    end
  end

  // channel and override stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_q[i] <= ppm_fd_pkg::FAILSAFE_MID;
        ovr_q[i]  <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (chan_we && (chan_widx == IdxW'(i))) begin
          chan_q[i] <= chan_wdata;
        end
        if (ovr_clr) begin
          ovr_q[i] <= '0;
        end else if (ovr_we && (ovr_widx == IdxW'(i))) begin
          ovr_q[i] <= ovr_wdata;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // slot index never climbs above its acquisition start
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q <= SlotRst)
    else $error("slot index above acquisition start");

  // no channel count is reported without sync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.has_sync) |-> (out_q.frame_channels == 4'd0))
    else $error("frame channels reported without sync");

  // an executed command always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> out_valid_q)
    else $error("executed command lost its result");

  // a sync pulse taken in sync restarts at slot zero with the flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.kind == ppm_fd_pkg::CMD_EDGE && synced &&
     width >= cfg_i.sync_threshold) |=> (slot_q == '0 && flag_q))
    else $error("sync pulse did not restart the frame");

endmodule

// ----- rtl/ppm_frame_decoder.sv -----
// ppm_frame_decoder: top level, configuration registers and the three units
// depends on ppm_fd_pkg, ppm_fd_front, ppm_fd_queue and ppm_fd_back

// Decodes a PPM sum signal from 16-bit capture timestamps and serves channel
// reads, override writes, override clears and frame polls, one result beat per
// input beat. The block takes one beat per cycle with no bubbles while the output
// side does not stall: the front stage registers and classifies the beat, a
// two-entry queue decouples it from the back unit, and the back unit updates all
// decoder state as it executes each command and parks the result in an output
// register, so a result passes through the front stage register, a queue entry and
// the output register. The configuration registers (sync threshold, min and max
// width) may be written only while no beat is in flight.

module ppm_frame_decoder #(
  parameter int unsigned CHANNEL_COUNT = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppm_fd_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ppm_fd_pkg::out_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  ppm_fd_pkg::cfg_t cfg_q;
  ppm_fd_pkg::cmd_t front_cmd, queue_cmd;
  logic             front_valid, front_ready;
  logic             queue_valid, queue_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_threshold <= ppm_fd_pkg::SYNC_THRESHOLD_RST;
      cfg_q.min_width      <= ppm_fd_pkg::MIN_WIDTH_RST;
      cfg_q.max_width      <= ppm_fd_pkg::MAX_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppm_fd_pkg::CFG_SYNC_THRESHOLD: cfg_q.sync_threshold <= cfg_data_i;
        ppm_fd_pkg::CFG_MIN_WIDTH:      cfg_q.min_width      <= cfg_data_i;
        ppm_fd_pkg::CFG_MAX_WIDTH:      cfg_q.max_width      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  ppm_fd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // command queue
  ppm_fd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_cmd)
  );

  // back: execute and hold results
  ppm_fd_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
